/* hdl/mono_bitmap_blit_rle_defines.svh */
// assertion macros used by the span queue
`ifndef MONO_BITMAP_BLIT_RLE_DEFINES_SVH
`define MONO_BITMAP_BLIT_RLE_DEFINES_SVH
`ifndef SYNTHESIS
`define MBB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mbb check failed");
`define MBB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mbb check failed");
`else
`define MBB_ASSERT(lbl, prop)
`define MBB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hdl/mbb_pkg.sv */
`timescale 1ns / 1ps
package mbb_pkg;

  // source formats
  localparam logic [1:0] MODE_RAW       = 2'd0;
  localparam logic [1:0] MODE_RAW_TRANS = 2'd1;
  localparam logic [1:0] MODE_RLE       = 2'd2;
  localparam logic [1:0] MODE_RLE_TRANS = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_CLIP_L   = 3'd4;
  localparam logic [2:0] REG_CLIP_T   = 3'd5;
  localparam logic [2:0] REG_CLIP_R   = 3'd6;
  localparam logic [2:0] REG_CLIP_B   = 3'd7;

  localparam int CFG_W = 11;

  // one visible horizontal span handed from front to back
  typedef struct packed {
    logic [15:0] base;   // row start offset in the frame buffer
    logic [9:0]  xf;     // first visible screen column
    logic [9:0]  xl;     // last visible screen column
    logic [2:0]  ph;     // low bits of the column of pixel 0
    logic [7:0]  vis;    // per-pixel visibility, pixel i at bit i
    logic [7:0]  col;    // per-pixel colour, pixel i at bit i
  } cmd_t;

endpackage

/* hdl/mbb_if.sv */
`timescale 1ns / 1ps
interface mbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       first;
  modport source (output valid, source_byte, first, input ready);
  modport sink (input valid, source_byte, first, output ready);
endinterface

interface mbb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dest_offset;
  logic [7:0]  write_mask;
  logic [7:0]  write_bits;
  logic        last;
  modport source (output valid, dest_offset, write_mask, write_bits, last, input ready);
  modport sink (input valid, dest_offset, write_mask, write_bits, last, output ready);
endinterface

/* hdl/mbb_front.sv */
`timescale 1ns / 1ps
module mbb_front #(
  parameter int LINE_BYTES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [mbb_pkg::CFG_W-1:0] cfg_data,
  mbb_in_if.sink                    src,
  input  logic                      q_full,
  output logic                      push,
  output mbb_pkg::cmd_t             cmd
);

  localparam int LBW = $clog2(LINE_BYTES + 1);

  logic [1:0]  mode;
  logic [10:0] origin_x, origin_y, bitmap_width;
  logic [9:0]  clip_l, clip_t, clip_r, clip_b;
  logic [11:0] column, row;
  logic [6:0]  literal_left;
  logic [11:0] column_next, row_next;
  logic [6:0]  literal_left_next;

  logic [11:0] col_f, row_f;
  logic [6:0]  ll_f;
  logic [7:0]  b;
  logic signed [14:0] ox, oy, y, x0r, xi, cl_s, cr_s;
  logic        y_in;
  logic [7:0]  raw_vis, raw_col;
  logic [2:0]  fi, li;
  logic        found;
  logic        trans, opq, clr;
  logic [6:0]  n_calc, np, ll_n;
  logic [12:0] sum13;
  logic        wrap;
  logic signed [14:0] cs, x0, xe, xf, xl;
  logic        run_vis;
  logic [11:0] c_adv;
  logic        adv_row;
  logic [LBW+9:0] prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mbb_pkg::MODE_RAW;
      origin_x <= '0;
      origin_y <= '0;
      bitmap_width <= 11'd1;
      clip_l <= '0;
      clip_t <= '0;
      clip_r <= '0;
      clip_b <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbb_pkg::REG_MODE:     mode <= cfg_data[1:0];
        mbb_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        mbb_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        mbb_pkg::REG_WIDTH:    bitmap_width <= cfg_data;
        mbb_pkg::REG_CLIP_L:   clip_l <= cfg_data[9:0];
        mbb_pkg::REG_CLIP_T:   clip_t <= cfg_data[9:0];
        mbb_pkg::REG_CLIP_R:   clip_r <= cfg_data[9:0];
        mbb_pkg::REG_CLIP_B:   clip_b <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // decode position state
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row <= '0;
      literal_left <= '0;
    end else if (src.valid && src.ready) begin
      column <= column_next;
      row <= row_next;
      literal_left <= literal_left_next;
    end
  end

  assign src.ready = !q_full;

  // classify the byte into one visible span
  always_comb begin
    b     = src.source_byte;
    col_f = src.first ? 12'd0 : column;
    row_f = src.first ? 12'd0 : row;
    ll_f  = src.first ? 7'd0 : literal_left;
    ox    = $signed({{4{origin_x[10]}}, origin_x});
    oy    = $signed({{4{origin_y[10]}}, origin_y});
    cl_s  = $signed({5'b00000, clip_l});
    cr_s  = $signed({5'b00000, clip_r});
    y     = oy + $signed({3'b000, row_f});
    y_in  = !y[14] && (y[13:0] >= {4'b0000, clip_t}) && (y[13:0] <= {4'b0000, clip_b});

    // raw formats, up to eight pixels
    x0r = ox + $signed({3'b000, col_f});
    raw_vis = '0;
    raw_col = '0;
    for (int i = 0; i < 8; i++) begin
      xi = x0r + $signed(15'(i));
      if (mode == mbb_pkg::MODE_RAW) begin
        raw_col[i] = b[7-i];
        raw_vis[i] = 1'b1;
      end else begin
        raw_col[i] = (i < 4) ? b[7-2*(i%4)] : 1'b0;
        raw_vis[i] = (i < 4) ? b[6-2*(i%4)] : 1'b0;
      end
      raw_vis[i] = raw_vis[i] && y_in && (({1'b0, col_f} + 13'(i)) < {2'b00, bitmap_width})
                   && !xi[14] && (xi[13:0] >= {4'b0000, clip_l})
                   && (xi[13:0] <= {4'b0000, clip_r});
    end
    fi = '0;
    li = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (raw_vis[i] && !found) begin
        fi = 3'(i);
        found = 1'b1;
      end
      if (raw_vis[i]) li = 3'(i);
    end

    // run-length formats
    trans  = (mode == mbb_pkg::MODE_RLE_TRANS);
    opq    = trans ? b[0] : 1'b1;
    clr    = trans ? b[1] : b[0];
    n_calc = (trans ? {2'b00, b[6:2]} : {1'b0, b[6:1]}) + 7'd1;
    if (ll_f != 7'd0) begin
      np = 7'd1;
      ll_n = ll_f - 7'd1;
    end else if (b[7]) begin
      np = n_calc;
      ll_n = ll_f;
    end else begin
      np = 7'd0;
      ll_n = n_calc;
    end
    // a run past column 4095 is only visible after the wrap, from column 0 on
    sum13 = {1'b0, col_f} + {6'b000000, np};
    wrap  = sum13 > 13'd4096;
    cs    = $signed({3'b000, col_f}) - (wrap ? 15'sd4096 : 15'sd0);
    x0    = ox + cs;
    xe    = x0 + $signed({8'b00000000, np}) - 15'sd1;
    xf    = wrap ? ((ox > cl_s) ? ox : cl_s) : ((x0 > cl_s) ? x0 : cl_s);
    xl    = (xe < cr_s) ? xe : cr_s;
    run_vis = (np != 7'd0) && opq && y_in && (xf <= xl);

    // next position
    if (!mode[1]) begin
      c_adv = col_f + ((mode == mbb_pkg::MODE_RAW) ? 12'd8 : 12'd4);
      adv_row = c_adv >= {1'b0, bitmap_width};
      literal_left_next = '0;
    end else begin
      c_adv = col_f + {5'b00000, np};
      adv_row = (c_adv >= {1'b0, bitmap_width}) &&
                (((ll_f != 7'd0) && (ll_n == 7'd0)) || ((ll_f == 7'd0) && b[7]));
      literal_left_next = ll_n;
    end
    column_next = adv_row ? 12'd0 : c_adv;
    row_next    = adv_row ? row_f + 12'd1 : row_f;

    // span out
    prod = y[9:0] * LBW'(LINE_BYTES);
    cmd.base = 16'(prod);
    if (!mode[1]) begin
      cmd.xf  = 10'(x0r + $signed({12'b0, fi}));
      cmd.xl  = 10'(x0r + $signed({12'b0, li}));
      cmd.ph  = x0r[2:0];
      cmd.vis = raw_vis;
      cmd.col = raw_col;
      push    = src.valid && src.ready && (raw_vis != 8'd0);
    end else begin
      cmd.xf  = xf[9:0];
      cmd.xl  = xl[9:0];
      cmd.ph  = x0[2:0];
      cmd.vis = 8'hff;
      cmd.col = {8{clr}};
      push    = src.valid && src.ready && run_vis;
    end
  end

endmodule

/* hdl/mbb_queue.sv */
`timescale 1ns / 1ps
`include "mono_bitmap_blit_rle_defines.svh"
module mbb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbb_pkg::cmd_t din,
  input  logic          pop,
  output mbb_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  mbb_pkg::cmd_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  // two-entry span store
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout  = mem[rp];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  `MBB_ASSERT(a_no_overflow, (push |-> !full))
  `MBB_ASSERT(a_no_underflow, (pop |-> !empty))
  `MBB_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 2'd1)
  `MBB_ASSERT(a_count_range, (count != 2'd3))

endmodule

/* hdl/mbb_back.sv */
`timescale 1ns / 1ps
module mbb_back (
  input  logic          clk,
  input  logic          rst,
  input  mbb_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  mbb_out_if.source     dst
);

  logic       started;
  logic [6:0] cur;
  logic [6:0] idx;
  logic       adv, fin;
  logic [9:0] x;
  logic [2:0] j;
  logic [7:0] mask, bits;

  // byte walk across the span
  always_comb begin
    idx = started ? cur : head.xf[9:3];
    fin = (idx == head.xl[9:3]);
    adv = head_valid && (!dst.valid || dst.ready);
    pop = adv && fin;
    mask = '0;
    bits = '0;
    for (int k = 0; k < 8; k++) begin
      x = {idx, 3'(k)};
      j = x[2:0] - head.ph;
      mask[7-k] = (x >= head.xf) && (x <= head.xl) && head.vis[j];
      bits[7-k] = mask[7-k] && head.col[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (adv) begin
      started <= !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cur <= idx + 7'd1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (adv) begin
      dst.valid <= 1'b1;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst.dest_offset <= head.base + {9'b000000000, idx};
      dst.write_mask  <= mask;
      dst.write_bits  <= bits;
      dst.last        <= fin;
    end
  end

endmodule

/* hdl/mono_bitmap_blit_rle.sv */
`timescale 1ns / 1ps
// Clipped 1bpp bitmap blitter with run-length decoding. Source bytes enter on src, one
// per cycle while the two-entry span queue has room; each byte is turned into at most
// one visible span of pixels, and the write stage then emits one masked frame-buffer
// byte write per cycle on dst unless dst holds it off with ready low. A raw byte gives
// one or two writes, a repeat run up to nine; the queue takes new bytes while the write
// stage still works on an earlier span. Registers are to be written through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block itself does not enforce this.
module mono_bitmap_blit_rle #(
  parameter int LINE_BYTES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [mbb_pkg::CFG_W-1:0] cfg_data,
  mbb_in_if.sink                    src,
  mbb_out_if.source                 dst
);

  logic          push, pop, full, empty;
  mbb_pkg::cmd_t cmd, head;

  // byte decode and clipping
  mbb_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .src(src), .q_full(full), .push(push), .cmd(cmd)
  );

  // span queue
  mbb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(cmd), .pop(pop), .dout(head),
    .full(full), .empty(empty)
  );

  // masked byte writes
  mbb_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(!empty), .pop(pop), .dst(dst)
  );

endmodule

/* sim/mono_bitmap_blit_rle_tb.sv */
`timescale 1ns / 1ps
module mono_bitmap_blit_rle_tb;

  localparam int LINE_BYTES = 16;
  localparam int TAIL_CYCLES = 30;

  typedef struct {
    logic [7:0] source_byte;
    logic       first;
  } src_item_t;

  typedef struct {
    logic [15:0] dest_offset;
    logic [7:0]  write_mask;
    logic [7:0]  write_bits;
    logic        last;
  } fb_write_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [2:0]                cfg_index;
  logic [mbb_pkg::CFG_W-1:0] cfg_data;

  mbb_in_if  src_if ();
  mbb_out_if dst_if ();

  mono_bitmap_blit_rle #(.LINE_BYTES(LINE_BYTES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_if.sink),
    .dst       (dst_if.source)
  );

  // blitter register copy
  logic [1:0]  blit_mode;
  int          org_x, org_y;
  int          bmp_width;
  int          clip_l, clip_t, clip_r, clip_b;

  // decoder state copy
  int          cur_col, cur_row, lit_left;

  // writes merged for the current byte
  fb_write_t   byte_writes[9];
  int          n_writes;

  src_item_t   pending_q[$];
  fb_write_t   fb_write_q[$];
  src_item_t   drv_item;
  fb_write_t   want;

  int          send_idle, recv_stall;
  int          n_errors, n_bytes, n_writes_seen, n_phases;

  // clock and simulation timeout
  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one visible pixel, merged into the write for the same frame-buffer byte
  function automatic void plot(int c, bit colour);
    int x, y, off;
    x = org_x + c;
    y = org_y + cur_row;
    if (x < clip_l || x > clip_r || y < clip_t || y > clip_b) return;
    off = (y * LINE_BYTES + (x >> 3)) & 16'hffff;
    if (n_writes > 0 && byte_writes[n_writes-1].dest_offset == off[15:0]) begin
      byte_writes[n_writes-1].write_mask[7 - (x & 7)] = 1'b1;
      byte_writes[n_writes-1].write_bits[7 - (x & 7)] = colour;
    end else if (n_writes < 9) begin
      byte_writes[n_writes].dest_offset = off[15:0];
      byte_writes[n_writes].write_mask  = 8'h00;
      byte_writes[n_writes].write_bits  = 8'h00;
      byte_writes[n_writes].last        = 1'b0;
      byte_writes[n_writes].write_mask[7 - (x & 7)] = 1'b1;
      byte_writes[n_writes].write_bits[7 - (x & 7)] = colour;
      n_writes++;
    end
  endfunction

  function automatic void advance_row();
    cur_col = 0;
    cur_row = (cur_row + 1) & 12'hfff;
  endfunction

  function automatic void run_px(bit opaque, bit colour);
    if (opaque) plot(cur_col, colour);
    cur_col = (cur_col + 1) & 12'hfff;
  endfunction

  // frame-buffer writes that one source byte produces
  function automatic void predict_writes(logic [7:0] b, logic first);
    int  shift, cnt;
    bit  opaque, colour;
    n_writes = 0;
    if (first) begin
      cur_col = 0;
      cur_row = 0;
      lit_left = 0;
    end
    case (blit_mode)
      mbb_pkg::MODE_RAW: begin
        lit_left = 0;
        for (int i = 0; i < 8; i++)
          if (cur_col + i < bmp_width) plot(cur_col + i, b[7 - i]);
        cur_col = (cur_col + 8) & 12'hfff;
        if (cur_col >= bmp_width) advance_row();
      end
      mbb_pkg::MODE_RAW_TRANS: begin
        lit_left = 0;
        for (int i = 0; i < 4; i++)
          if (cur_col + i < bmp_width && b[6 - 2*i]) plot(cur_col + i, b[7 - 2*i]);
        cur_col = (cur_col + 4) & 12'hfff;
        if (cur_col >= bmp_width) advance_row();
      end
      default: begin
        shift  = (blit_mode == mbb_pkg::MODE_RLE_TRANS) ? 2 : 1;
        opaque = (blit_mode == mbb_pkg::MODE_RLE_TRANS) ? b[0] : 1'b1;
        colour = (blit_mode == mbb_pkg::MODE_RLE_TRANS) ? b[1] : b[0];
        if (lit_left != 0) begin
          run_px(opaque, colour);
          lit_left = (lit_left - 1) & 7'h7f;
          if (lit_left == 0 && cur_col >= bmp_width) advance_row();
        end else if (b[7]) begin
          cnt = ((b & 8'h7f) >> shift) + 1;
          for (int i = 0; i < cnt; i++) run_px(opaque, colour);
          if (cur_col >= bmp_width) advance_row();
        end else begin
          lit_left = ((b >> shift) + 1) & 7'h7f;
        end
      end
    endcase
    for (int i = 0; i < n_writes; i++) begin
      byte_writes[i].last = (i == n_writes - 1);
      fb_write_q.push_back(byte_writes[i]);
    end
  endfunction

  // source driver: takes items from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      src_if.valid <= 1'b0;
    end else begin
      if (src_if.valid && src_if.ready) begin
        predict_writes(src_if.source_byte, src_if.first);
        n_bytes++;
      end
      if (!src_if.valid || src_if.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv_item = pending_q.pop_front();
          src_if.valid       <= 1'b1;
          src_if.source_byte <= drv_item.source_byte;
          src_if.first       <= drv_item.first;
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // write monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      dst_if.ready <= 1'b0;
    end else begin
      dst_if.ready <= ($urandom_range(99) >= recv_stall);
      if (dst_if.valid && dst_if.ready) begin
        n_writes_seen++;
        if (fb_write_q.size() == 0) begin
          $error("unexpected write: dest_offset %h", dst_if.dest_offset);
          n_errors++;
        end else begin
          want = fb_write_q.pop_front();
          if (dst_if.dest_offset !== want.dest_offset) begin
            $error("dest_offset exp %h got %h", want.dest_offset, dst_if.dest_offset);
            n_errors++;
          end
          if (dst_if.write_mask !== want.write_mask) begin
            $error("write_mask exp %h got %h", want.write_mask, dst_if.write_mask);
            n_errors++;
          end
          if (dst_if.write_bits !== want.write_bits) begin
            $error("write_bits exp %h got %h", want.write_bits, dst_if.write_bits);
            n_errors++;
          end
          if (dst_if.last !== want.last) begin
            $error("last exp %b got %b", want.last, dst_if.last);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[mbb_pkg::CFG_W-1:0];
    case (idx)
      mbb_pkg::REG_MODE:     blit_mode = value[1:0];
      mbb_pkg::REG_ORIGIN_X: org_x = $signed(value[10:0]);
      mbb_pkg::REG_ORIGIN_Y: org_y = $signed(value[10:0]);
      mbb_pkg::REG_WIDTH:    bmp_width = value[10:0];
      mbb_pkg::REG_CLIP_L:   clip_l = value[9:0];
      mbb_pkg::REG_CLIP_T:   clip_t = value[9:0];
      mbb_pkg::REG_CLIP_R:   clip_r = value[9:0];
      mbb_pkg::REG_CLIP_B:   clip_b = value[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int m, int ox, int oy, int w, int cl, int ct, int cr, int cb);
    write_reg(mbb_pkg::REG_MODE, m);
    write_reg(mbb_pkg::REG_ORIGIN_X, ox);
    write_reg(mbb_pkg::REG_ORIGIN_Y, oy);
    write_reg(mbb_pkg::REG_WIDTH, w);
    write_reg(mbb_pkg::REG_CLIP_L, cl);
    write_reg(mbb_pkg::REG_CLIP_T, ct);
    write_reg(mbb_pkg::REG_CLIP_R, cr);
    write_reg(mbb_pkg::REG_CLIP_B, cb);
  endtask

  task automatic push_byte(int b, bit f = 1'b0);
    src_item_t it;
    it.source_byte = b[7:0];
    it.first       = f;
    pending_q.push_back(it);
  endtask

  // let everything drain, then allow for a header still in flight
  task automatic drain();
    while (pending_q.size() != 0 || src_if.valid || fb_write_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  task automatic pick_idling(int p);
    case (p % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 52; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 52; end
      default: begin send_idle = 9; recv_stall = 9; end
    endcase
  endtask

  // well-formed run-length streams with some noise bytes mixed in
  task automatic gen_rle(int n, bit trans);
    int shift, cnt, maxc, lo;
    shift = trans ? 2 : 1;
    maxc  = trans ? 32 : 64;
    while (n > 0) begin
      lo = $urandom_range((1 << shift) - 1);
      if ($urandom_range(9) == 0) begin
        push_byte($urandom_range(255));
        n--;
      end else if ($urandom_range(1)) begin
        cnt = ($urandom_range(7) == 0) ? maxc : $urandom_range(1, 12);
        push_byte(8'h80 | ((cnt - 1) << shift) | lo);
        n--;
      end else begin
        cnt = ($urandom_range(15) == 0) ? $urandom_range(1, maxc) : $urandom_range(1, 4);
        push_byte(((cnt - 1) << shift) | lo);
        for (int i = 0; i < cnt; i++) push_byte($urandom_range(255));
        n -= cnt + 1;
      end
    end
  endtask

  initial begin
    int m, w, ox, oy, cl, ct;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mbb_pkg::REG_MODE;
    cfg_data = '0;
    src_if.valid = 1'b0;
    src_if.source_byte = 8'h00;
    src_if.first = 1'b0;
    dst_if.ready = 1'b0;
    blit_mode = mbb_pkg::MODE_RAW;
    org_x = 0; org_y = 0; bmp_width = 1;
    clip_l = 0; clip_t = 0; clip_r = 0; clip_b = 0;
    cur_col = 0; cur_row = 0; lit_left = 0;
    n_errors = 0; n_bytes = 0; n_writes_seen = 0; n_phases = 0;
    send_idle = 0; recv_stall = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one-pixel bitmap at the single clip pixel
    push_byte(8'hff, 1'b1); push_byte(8'h00); push_byte(8'h80);
    drain();

    // raw with row padding, partly off the left and top edges
    setup(mbb_pkg::MODE_RAW, -3, -1, 13, 0, 0, 20, 5);
    push_byte(8'hff, 1'b1); push_byte(8'h00); push_byte(8'ha5);
    push_byte(8'h5a); push_byte(8'hff); push_byte(8'hff);
    drain();

    // raw transparent at the right screen edge
    setup(mbb_pkg::MODE_RAW_TRANS, 1016, 1023, 20, 0, 0, 1023, 1023);
    push_byte(8'hff, 1'b1); push_byte(8'h55); push_byte(8'haa); push_byte(8'h00);
    push_byte(8'hcc);
    drain();

    // run-length, zero width, run overrun, extreme runs
    setup(mbb_pkg::MODE_RLE, 0, 0, 0, 0, 0, 1023, 1023);
    push_byte(8'hff, 1'b1); push_byte(8'h80); push_byte(8'h02);
    push_byte(8'h01); push_byte(8'h00);
    drain();

    // transparent runs crossing a short row, then a literal header left open
    setup(mbb_pkg::MODE_RLE_TRANS, -1024, -1024, 5, 0, 0, 1023, 1023);
    push_byte(8'hff, 1'b1);
    drain();
    setup(mbb_pkg::MODE_RLE_TRANS, 2, 3, 5, 0, 0, 1023, 1023);
    push_byte(8'h9f, 1'b1); push_byte(8'h8e); push_byte(8'h04);
    push_byte(8'h03); push_byte(8'h02);
    push_byte(8'h04);
    drain();

    // mode change with a literal pending, then an empty clip
    setup(mbb_pkg::MODE_RAW, 2, 3, 5, 0, 0, 1023, 1023);
    push_byte(8'hf0);
    drain();
    setup(mbb_pkg::MODE_RLE, 0, 0, 8, 10, 0, 9, 1023);
    push_byte(8'hff, 1'b1); push_byte(8'h05); push_byte(8'h01);
    drain();

    // random settings under each idling pattern
    for (int p = 0; p < 8; p++) begin
      pick_idling(p);
      m  = $urandom_range(3);
      w  = ($urandom_range(5) == 0) ? 1024 : $urandom_range(1, 40);
      ox = $urandom_range(7) == 0 ? -1024 : $urandom_range(0, 60) - 20;
      oy = $urandom_range(7) == 0 ? 1023 : $urandom_range(0, 40) - 10;
      cl = $urandom_range(0, 30);
      ct = $urandom_range(0, 10);
      setup(m, ox, oy, w, cl, ct, cl + $urandom_range(0, 40), ct + $urandom_range(0, 20));
      if (m >= mbb_pkg::MODE_RLE) begin
        push_byte(8'h80 | $urandom_range(127), 1'b1);
        gen_rle(13, m == mbb_pkg::MODE_RLE_TRANS);
      end else begin
        push_byte($urandom_range(255), 1'b1);
        for (int i = 0; i < 13; i++) push_byte($urandom_range(255), $urandom_range(15) == 0);
      end
      drain();
    end

    $display("covered %0d source bytes and %0d frame-buffer writes over %0d phases",
             n_bytes, n_writes_seen, n_phases);
    $display("all four formats, clip edges, zero width and run overrun exercised");
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
